@@ hw/rtl/tpt_pkg.sv @@
`default_nettype none

package tpt_pkg;

  // Fixed field widths of the channels
  localparam int VA_W       = 26;
  localparam int PA_W       = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PAGE_BITS   = 10;
  localparam int DEF_MAX_FRAMES      = 256;
  localparam int DEF_TLB_DEPTH       = 16;
  localparam int DEF_MAX_OFFSET_BITS = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_NUMBER_BITS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TLB_ENTRIES_USED = 4'd3;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_NO_FRAME = 2'd2
  } status_t;

  // Clamped configuration as the datapath uses it
  typedef struct packed {
    logic [4:0] off_bits;
    logic [4:0] page_bits;
    logic [8:0] frame_count;
    logic [4:0] tlb_used;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic decode;
    logic lookup;
    logic resolve;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/tpt_ifs.sv @@
`default_nettype none

// Virtual address channel
interface tpt_in_if import tpt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VA_W-1:0] vaddr;

  modport source (output valid, output vaddr, input ready);
  modport sink (input valid, input vaddr, output ready);
endinterface

// Translation result channel
interface tpt_out_if import tpt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] paddr;
  logic            tlb_hit;
  logic [1:0]      status;

  modport source (output valid, output paddr, output tlb_hit, output status,
                  input ready);
  modport sink (input valid, input paddr, input tlb_hit, input status,
                output ready);
endinterface

// Configuration write channel
interface tpt_cfg_if import tpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tlb_page_translate_alloc.sv @@
`default_nettype none

// Channel   Dir  Payload                        Transfer
// in_ch     in   vaddr[25:0]                    valid && ready
// out_ch    out  paddr[23:0], tlb_hit, status   valid && ready
// cfg_ch    in   index[3:0], data[8:0]          valid && ready (ready tied high)
//
// Each item passes through the controller states idle, decode, lookup (TLB compare and
// page table read together), resolve and form, in that order.
// After reset a clearing pass writes every page table entry (2^MAX_PAGE_BITS of them,
// 1024 by default); in_ch.ready stays low until it ends.
// A result waiting on out_ch does not block the next input transfer; the item after
// it stalls in its form step until the output register is free.

module tlb_page_translate_alloc import tpt_pkg::*; #(
  parameter int MAX_PAGE_BITS   = DEF_MAX_PAGE_BITS,
  parameter int MAX_FRAMES      = DEF_MAX_FRAMES,
  parameter int TLB_DEPTH       = DEF_TLB_DEPTH,
  parameter int MAX_OFFSET_BITS = DEF_MAX_OFFSET_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tpt_in_if.sink     in_ch,
  tpt_out_if.source  out_ch,
  tpt_cfg_if.sink    cfg_ch
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  tpt_cfg_regs #(
    .MAX_PAGE_BITS   (MAX_PAGE_BITS),
    .TLB_DEPTH       (TLB_DEPTH),
    .MAX_OFFSET_BITS (MAX_OFFSET_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  tpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpt_datapath #(
    .MAX_PAGE_BITS   (MAX_PAGE_BITS),
    .MAX_FRAMES      (MAX_FRAMES),
    .TLB_DEPTH       (TLB_DEPTH),
    .MAX_OFFSET_BITS (MAX_OFFSET_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg),
    .in_va      (in_ch.vaddr),
    .out_pa     (out_ch.paddr),
    .out_hit    (out_ch.tlb_hit),
    .out_status (out_ch.status)
  );

  // No input transfer during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !in_ch.ready)
    else $error("input ready during page table clear");

  // One item at a time: ready drops after each input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after a transfer");

  // Never overwrite a result that the sink has not taken
  a_emit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result emitted over a pending transfer");

  // A new result appears only after the emit step
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.emit))
    else $error("output valid without emit");

endmodule

`default_nettype wire

@@ hw/rtl/tpt_cfg_regs.sv @@
`default_nettype none

module tpt_cfg_regs import tpt_pkg::*; #(
  parameter int MAX_PAGE_BITS   = DEF_MAX_PAGE_BITS,
  parameter int TLB_DEPTH       = DEF_TLB_DEPTH,
  parameter int MAX_OFFSET_BITS = DEF_MAX_OFFSET_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  logic [4:0] off_bits_r;
  logic [3:0] page_bits_r;
  logic [8:0] frame_count_r;
  logic [4:0] tlb_used_r;

  // Store register writes, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_bits_r    <= 5'd12;
      page_bits_r   <= 4'd10;
      frame_count_r <= 9'd256;
      tlb_used_r    <= 5'd16;
    end else if (wr_en) begin
      unique case (wr_idx)
        CFG_OFFSET_BITS:      off_bits_r    <= wr_data[4:0];
        CFG_PAGE_NUMBER_BITS: page_bits_r   <= wr_data[3:0];
        CFG_FRAME_COUNT:      frame_count_r <= wr_data[8:0];
        CFG_TLB_ENTRIES_USED: tlb_used_r    <= wr_data[4:0];
        default: ;
      endcase
    end
  end

  // Clamp the offset, page number and TLB entry registers to their usable ranges; the frame count passes through
  always_comb begin
    if (off_bits_r == 5'd0)
      cfg.off_bits = 5'd1;
    else if (int'(off_bits_r) > MAX_OFFSET_BITS)
      cfg.off_bits = 5'(MAX_OFFSET_BITS);
    else
      cfg.off_bits = off_bits_r;

    if (page_bits_r == 4'd0)
      cfg.page_bits = 5'd1;
    else if (int'(page_bits_r) > MAX_PAGE_BITS)
      cfg.page_bits = 5'(MAX_PAGE_BITS);
    else
      cfg.page_bits = {1'b0, page_bits_r};

    if (tlb_used_r == 5'd0)
      cfg.tlb_used = 5'd1;
    else if (int'(tlb_used_r) > TLB_DEPTH)
      cfg.tlb_used = 5'(TLB_DEPTH);
    else
      cfg.tlb_used = tlb_used_r;

    cfg.frame_count = frame_count_r;
  end

endmodule

`default_nettype wire

@@ hw/rtl/tpt_ctrl.sv @@
`default_nettype none

module tpt_ctrl import tpt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  dp_stat_t  stat,
  output dp_cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_DECODE  = 6'b000100,
    ST_LOOKUP  = 6'b001000,
    ST_RESOLVE = 6'b010000,
    ST_FORM    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit_ok;

  assign emit_ok   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Run the clearing pass after reset, then sequence one translation through its steps
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = ST_FORM;
      end
      ST_FORM: begin
        if (emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Hold the result until the sink takes the transfer
  always_comb begin
    if (cmd.emit)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tpt_datapath.sv @@
`default_nettype none

module tpt_datapath import tpt_pkg::*; #(
  parameter int MAX_PAGE_BITS   = DEF_MAX_PAGE_BITS,
  parameter int MAX_FRAMES      = DEF_MAX_FRAMES,
  parameter int TLB_DEPTH       = DEF_TLB_DEPTH,
  parameter int MAX_OFFSET_BITS = DEF_MAX_OFFSET_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  cfg_t                 cfg,
  input  wire logic [VA_W-1:0] in_va,
  output logic [PA_W-1:0]      out_pa,
  output logic                 out_hit,
  output logic [1:0]           out_status
);

  localparam int PAGE_W     = MAX_PAGE_BITS;
  localparam int PAGE_DEPTH = 1 << MAX_PAGE_BITS;
  localparam int OFF_W      = MAX_OFFSET_BITS;
  localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int SLOT_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int PE_W       = FRAME_W + 1;

  // Item registers
  logic [VA_W-1:0]    va_r;
  logic               oor_r;
  logic [PAGE_W-1:0]  page_r;
  logic [OFF_W-1:0]   offset_r;
  logic [TLB_DEPTH-1:0] match_r;
  logic [PE_W-1:0]    pt_rd_r;
  logic [FRAME_W-1:0] frame_r;
  logic               hit_r;
  status_t            status_r;

  // Block state
  logic [PE_W-1:0]    pt_mem [PAGE_DEPTH];
  logic [PAGE_W-1:0]  clr_r;
  logic [CNT_W-1:0]   alloc_r;
  logic [SLOT_W-1:0]  fp_r;
  logic [TLB_DEPTH-1:0] tlb_v_r;
  logic [PAGE_W-1:0]  tlb_page_r  [TLB_DEPTH];
  logic [FRAME_W-1:0] tlb_frame_r [TLB_DEPTH];

  assign stat.clear_last = (clr_r == {PAGE_W{1'b1}});

  // Capture the address on the input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) va_r <= in_va;
  end

  // Split the address and check its range
  logic [5:0]      span_c;
  logic [VA_W-1:0] off_mask_c;
  logic [VA_W-1:0] page_mask_c;
  logic [VA_W-1:0] page_sh_c;

  always_comb begin
    span_c      = {1'b0, cfg.off_bits} + {1'b0, cfg.page_bits};
    off_mask_c  = (VA_W'(1) << cfg.off_bits) - VA_W'(1);
    page_mask_c = (VA_W'(1) << cfg.page_bits) - VA_W'(1);
    page_sh_c   = va_r >> cfg.off_bits;
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      oor_r    <= ((va_r >> span_c) != '0);
      offset_r <= OFF_W'(va_r & off_mask_c);
      page_r   <= PAGE_W'(page_sh_c & page_mask_c);
    end
  end

  // Compare the page against every TLB slot in use
  logic [TLB_DEPTH-1:0] match_c;

  always_comb begin
    for (int i = 0; i < TLB_DEPTH; i++) begin
      match_c[i] = tlb_v_r[i] && (tlb_page_r[i] == page_r) && (i < int'(cfg.tlb_used));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) match_r <= match_c;
  end

  // Pick the lowest matching slot
  logic              hit_c;
  logic [SLOT_W-1:0] hit_idx_c;

  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_c     = 1'b1;
        hit_idx_c = SLOT_W'(i);
      end
    end
  end

  // Decide the frame: TLB, page table or a fresh allocation, else a range or no-frame status
  logic               can_alloc_c;
  logic               do_alloc_c;
  logic               do_insert_c;
  logic [FRAME_W-1:0] frame_c;
  logic               res_hit_c;
  status_t            status_c;
  logic [SLOT_W-1:0]  slot_c;
  logic [SLOT_W-1:0]  fp_nxt;
  int                 slot_inc_c;

  always_comb begin
    can_alloc_c = (int'(alloc_r) < int'(cfg.frame_count)) && (int'(alloc_r) < MAX_FRAMES);
    do_alloc_c  = 1'b0;
    do_insert_c = 1'b0;
    frame_c     = '0;
    res_hit_c   = 1'b0;
    status_c    = STAT_OK;
    priority if (oor_r) begin
      status_c = STAT_RANGE;
    end else if (hit_c) begin
      frame_c   = tlb_frame_r[hit_idx_c];
      res_hit_c = 1'b1;
    end else if (pt_rd_r[PE_W-1]) begin
      frame_c     = pt_rd_r[FRAME_W-1:0];
      do_insert_c = 1'b1;
    end else if (can_alloc_c) begin
      frame_c     = FRAME_W'(alloc_r);
      do_alloc_c  = 1'b1;
      do_insert_c = 1'b1;
    end else begin
      status_c = STAT_NO_FRAME;
    end

    slot_c     = (int'(fp_r) >= int'(cfg.tlb_used)) ? '0 : fp_r;
    slot_inc_c = int'(slot_c) + 1;
    fp_nxt     = (slot_inc_c >= int'(cfg.tlb_used)) ? '0 : SLOT_W'(slot_inc_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      frame_r  <= frame_c;
      hit_r    <= res_hit_c;
      status_r <= status_c;
    end
  end

  // Advance the clear counter, fill pointer, allocation count and TLB valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r    <= '0;
      alloc_r <= '0;
      tlb_v_r <= '0;
      clr_r   <= '0;
    end else begin
      if (cmd.clear_step) clr_r <= clr_r + PAGE_W'(1);
      if (cmd.resolve && do_alloc_c) alloc_r <= alloc_r + CNT_W'(1);
      if (cmd.resolve && do_insert_c) begin
        tlb_v_r[slot_c] <= 1'b1;
        fp_r            <= fp_nxt;
      end
    end
  end

  // Write the TLB slot payload
  always_ff @(posedge clk) begin
    if (cmd.resolve && do_insert_c) begin
      tlb_page_r[slot_c]  <= page_r;
      tlb_frame_r[slot_c] <= frame_c;
    end
  end

  // Page table memory: one write port, registered read
  logic              pt_we_c;
  logic [PAGE_W-1:0] pt_wa_c;
  logic [PE_W-1:0]   pt_wd_c;

  always_comb begin
    pt_we_c = cmd.clear_step || (cmd.resolve && do_alloc_c);
    pt_wa_c = cmd.clear_step ? clr_r : page_r;
    pt_wd_c = cmd.clear_step ? '0 : {1'b1, frame_c};
  end

  always_ff @(posedge clk) begin
    if (pt_we_c) pt_mem[pt_wa_c] <= pt_wd_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) pt_rd_r <= pt_mem[page_r];
  end

  // Form the physical address into the output register
  logic [PA_W-1:0] pa_c;

  always_comb begin
    pa_c = (PA_W'(frame_r) << cfg.off_bits) | PA_W'(offset_r);
    if (status_r != STAT_OK) pa_c = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pa     <= pa_c;
      out_hit    <= hit_r;
      out_status <= status_r;
    end
  end

endmodule

`default_nettype wire
